[sv/ssp_pkg.sv]
`default_nettype none

package ssp_pkg;

    localparam int VERT_W   = 6;
    localparam int DIST_W   = 30;
    localparam int KEY_W    = DIST_W + VERT_W;
    localparam int STATUS_W = 2;
    localparam int VCOUNT_W = 7;

    localparam logic [DIST_W-1:0] INF_DIST = 30'h3f3f3f3f;

    localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_SOURCE  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EDGE_REJECT = 2'd2;

    // request to the heap unit, at most one of push, pop, clear per cycle
    typedef struct packed {
        logic             push;
        logic             pop;
        logic             clear;
        logic [KEY_W-1:0] key;
    } heap_cmd_t;

    typedef struct packed {
        logic             busy;
        logic             empty;
        logic [KEY_W-1:0] top_key;
    } heap_stat_t;

endpackage

`default_nettype wire

[sv/single_source_shortest_path.sv]
// Shortest distances from one source on a small undirected weighted graph.
// An s_ transaction with mode 0 adds an edge: both directions go into the
// edge table and nothing is returned, unless a vertex is not below the
// vertex count or the table is full, in which case one result with status 2
// comes back. Mode 1 runs from the source vertex and returns one result per
// vertex in vertex order, last set on the final one; an invalid source gives
// one result with status 1. The block takes one transaction at a time and is
// not ready while it works. A run first sets every distance to infinity,
// then for each heap entry popped scans every stored edge (an edge from the
// popped vertex reads the distance memory, and a sift-up in the heap unit
// follows when a distance improves), then reports each vertex, waiting on
// m_ready. vertex_count is written through cfg_; the user must write it only
// while the block is idle, and the block itself does not enforce this.
`default_nettype none

module single_source_shortest_path #(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_EDGES    = 256,
    parameter int WEIGHT_BITS  = 16,
    parameter int HEAP_DEPTH   = 1024
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration: vertex count
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [6:0]  cfg_data,
    // input transactions
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_mode,
    input  wire logic [5:0]  s_from_vertex,
    input  wire logic [5:0]  s_to_vertex,
    input  wire logic [15:0] s_edge_weight,
    // result transactions
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [5:0]       m_vertex,
    output logic [29:0]      m_distance,
    output logic [1:0]       m_status,
    output logic             m_last
);

    localparam int VW    = ssp_pkg::VERT_W;
    localparam int DW    = ssp_pkg::DIST_W;
    localparam int CW    = ssp_pkg::VCOUNT_W;
    localparam int VA_W  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int SLOTS = 2 * MAX_EDGES;
    localparam int EA_W  = $clog2(SLOTS);
    localparam int EC_W  = $clog2(SLOTS + 1);
    localparam int EW    = 2 * VW + WEIGHT_BITS;
    localparam longint WMAX = (64'd1 << WEIGHT_BITS) - 64'd1;

    typedef enum logic [3:0] {
        ST_IDLE, ST_EDGE2, ST_INIT, ST_START, ST_POP, ST_POP_WAIT, ST_DU_LD,
        ST_SCAN, ST_EDGE_CHK, ST_DV_CHK, ST_PUSH_WAIT, ST_OUT_RD, ST_OUT_LD,
        ST_OUT_WAIT
    } state_t;

    state_t                 state_reg, state_next;
    logic [CW-1:0]          vc_reg, vc_next;
    logic [EC_W-1:0]        ec_reg, ec_next;
    logic [EC_W-1:0]        e_reg, e_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic [VW-1:0]          a_reg, a_next;
    logic [VW-1:0]          b_reg, b_next;
    logic [WEIGHT_BITS-1:0] w_reg, w_next;
    logic [VW-1:0]          u_reg, u_next;
    logic [DW-1:0]          du_reg, du_next;
    logic                   m_valid_reg, m_valid_next;
    logic [VW-1:0]          m_vertex_reg, m_vertex_next;
    logic [DW-1:0]          m_distance_reg, m_distance_next;
    logic [1:0]             m_status_reg, m_status_next;
    logic                   m_last_reg, m_last_next;

    // edge table: {from, to, weight}
    logic [EW-1:0]          edge_mem [SLOTS];
    logic                   edge_we;
    logic [EA_W-1:0]        edge_wa, edge_ra;
    logic [EW-1:0]          edge_wd, edge_q;

    // distance per vertex
    logic [DW-1:0]          dist_mem [MAX_VERTICES];
    logic                   dist_we;
    logic [VA_W-1:0]        dist_wa, dist_ra;
    logic [DW-1:0]          dist_wd, dist_q;

    ssp_pkg::heap_cmd_t     hcmd;
    ssp_pkg::heap_stat_t    hstat;

    logic [CW-1:0]          n_act;
    logic [31:0]            w_wide;
    logic [WEIGHT_BITS-1:0] w_sat;
    logic [VW-1:0]          e_from, e_to, pop_u;
    logic [WEIGHT_BITS-1:0] e_wt;
    logic [DW:0]            nd;

    ssp_heap #(
        .HEAP_DEPTH (HEAP_DEPTH)
    ) u_heap (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (hcmd),
        .stat    (hstat)
    );

    always_ff @(posedge aclk) begin
        if (edge_we) begin
            edge_mem[edge_wa] <= edge_wd;
        end
        edge_q <= edge_mem[edge_ra];
    end

    always_ff @(posedge aclk) begin
        if (dist_we) begin
            dist_mem[dist_wa] <= dist_wd;
        end
        dist_q <= dist_mem[dist_ra];
    end

    // effective vertex count: zero acts as one, clamp at the maximum
    assign n_act = (vc_reg == '0) ? CW'(1) :
                   (32'(vc_reg) > MAX_VERTICES) ? CW'(MAX_VERTICES) : vc_reg;

    assign w_wide = 32'(s_edge_weight);
    assign w_sat  = (64'(w_wide) > WMAX) ? '1 : w_wide[WEIGHT_BITS-1:0];

    assign e_from = edge_q[EW-1 -: VW];
    assign e_to   = edge_q[WEIGHT_BITS +: VW];
    assign e_wt   = edge_q[WEIGHT_BITS-1:0];
    assign pop_u  = hstat.top_key[VW-1:0];
    assign nd     = {1'b0, du_reg} + (DW+1)'(w_reg);

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);

    always_comb begin
        state_next      = state_reg;
        vc_next         = vc_reg;
        ec_next         = ec_reg;
        e_next          = e_reg;
        cnt_next        = cnt_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        w_next          = w_reg;
        u_next          = u_reg;
        du_next         = du_reg;
        m_valid_next    = m_valid_reg;
        m_vertex_next   = m_vertex_reg;
        m_distance_next = m_distance_reg;
        m_status_next   = m_status_reg;
        m_last_next     = m_last_reg;
        edge_we         = 1'b0;
        edge_wa         = ec_reg[EA_W-1:0];
        edge_wd         = {a_reg, b_reg, w_reg};
        edge_ra         = e_reg[EA_W-1:0];
        dist_we         = 1'b0;
        dist_wa         = cnt_reg[VA_W-1:0];
        dist_wd         = ssp_pkg::INF_DIST;
        dist_ra         = cnt_reg[VA_W-1:0];
        hcmd            = '0;

        if (cfg_valid) begin
            vc_next = cfg_data;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    a_next = s_from_vertex;
                    b_next = s_to_vertex;
                    w_next = w_sat;
                    if (!s_mode) begin
                        if (({1'b0, s_from_vertex} >= n_act) ||
                            ({1'b0, s_to_vertex} >= n_act) ||
                            (32'(ec_reg) + 2 > SLOTS)) begin
                            m_valid_next    = 1'b1;
                            m_vertex_next   = '0;
                            m_distance_next = '0;
                            m_status_next   = ssp_pkg::STATUS_EDGE_REJECT;
                            m_last_next     = 1'b1;
                            state_next      = ST_OUT_WAIT;
                        end else begin
                            edge_we    = 1'b1;
                            edge_wd    = {s_from_vertex, s_to_vertex, w_sat};
                            state_next = ST_EDGE2;
                        end
                    end else if ({1'b0, s_from_vertex} >= n_act) begin
                        m_valid_next    = 1'b1;
                        m_vertex_next   = s_from_vertex;
                        m_distance_next = '0;
                        m_status_next   = ssp_pkg::STATUS_BAD_SOURCE;
                        m_last_next     = 1'b1;
                        state_next      = ST_OUT_WAIT;
                    end else begin
                        hcmd.clear = 1'b1;
                        cnt_next   = '0;
                        state_next = ST_INIT;
                    end
                end
            end
            // reverse direction of the new edge
            ST_EDGE2: begin
                edge_we    = 1'b1;
                edge_wa    = EA_W'(ec_reg + 1'b1);
                edge_wd    = {b_reg, a_reg, w_reg};
                ec_next    = ec_reg + EC_W'(2);
                state_next = ST_IDLE;
            end
            // every distance to infinity
            ST_INIT: begin
                dist_we = 1'b1;
                if (cnt_reg == CW'(MAX_VERTICES - 1)) begin
                    state_next = ST_START;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_START: begin
                dist_we    = 1'b1;
                dist_wa    = a_reg[VA_W-1:0];
                dist_wd    = '0;
                hcmd.push  = 1'b1;
                hcmd.key   = {{DW{1'b0}}, a_reg};
                state_next = ST_POP;
            end
            ST_POP: begin
                if (!hstat.busy) begin
                    if (hstat.empty) begin
                        cnt_next   = '0;
                        state_next = ST_OUT_RD;
                    end else begin
                        hcmd.pop   = 1'b1;
                        state_next = ST_POP_WAIT;
                    end
                end
            end
            ST_POP_WAIT: begin
                if (!hstat.busy) begin
                    u_next  = pop_u;
                    dist_ra = pop_u[VA_W-1:0];
                    state_next = ({1'b0, pop_u} >= n_act) ? ST_POP : ST_DU_LD;
                end
            end
            ST_DU_LD: begin
                du_next    = dist_q;
                e_next     = '0;
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (e_reg >= ec_reg) begin
                    state_next = ST_POP;
                end else begin
                    state_next = ST_EDGE_CHK;
                end
            end
            ST_EDGE_CHK: begin
                if ((e_from == u_reg) && ({1'b0, e_to} < n_act)) begin
                    dist_ra    = e_to[VA_W-1:0];
                    b_next     = e_to;
                    w_next     = e_wt;
                    state_next = ST_DV_CHK;
                end else begin
                    e_next     = e_reg + 1'b1;
                    state_next = ST_SCAN;
                end
            end
            // relax: shorter path found, record it and push a fresh copy
            ST_DV_CHK: begin
                if ({1'b0, dist_q} > nd) begin
                    dist_we    = 1'b1;
                    dist_wa    = b_reg[VA_W-1:0];
                    dist_wd    = nd[DW-1:0];
                    hcmd.push  = 1'b1;
                    hcmd.key   = {nd[DW-1:0], b_reg};
                    state_next = ST_PUSH_WAIT;
                end else begin
                    e_next     = e_reg + 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_PUSH_WAIT: begin
                if (!hstat.busy) begin
                    e_next     = e_reg + 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_OUT_RD: begin
                state_next = ST_OUT_LD;
            end
            ST_OUT_LD: begin
                m_valid_next    = 1'b1;
                m_vertex_next   = cnt_reg[VW-1:0];
                m_distance_next = dist_q;
                m_status_next   = ssp_pkg::STATUS_OK;
                m_last_next     = (cnt_reg + 1'b1 == n_act);
                state_next      = ST_OUT_WAIT;
            end
            ST_OUT_WAIT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    if (m_last_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        cnt_next   = cnt_reg + 1'b1;
                        state_next = ST_OUT_RD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            vc_reg      <= CW'(64);
            ec_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            vc_reg      <= vc_next;
            ec_reg      <= ec_next;
            m_valid_reg <= m_valid_next;
        end
        e_reg          <= e_next;
        cnt_reg        <= cnt_next;
        a_reg          <= a_next;
        b_reg          <= b_next;
        w_reg          <= w_next;
        u_reg          <= u_next;
        du_reg         <= du_next;
        m_vertex_reg   <= m_vertex_next;
        m_distance_reg <= m_distance_next;
        m_status_reg   <= m_status_next;
        m_last_reg     <= m_last_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_vertex   = m_vertex_reg;
    assign m_distance = m_distance_reg;
    assign m_status   = m_status_reg;
    assign m_last     = m_last_reg;

endmodule

`default_nettype wire

[sv/ssp_heap.sv]
`default_nettype none

module ssp_heap #(
    parameter int HEAP_DEPTH = 1024
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire ssp_pkg::heap_cmd_t cmd,
    output ssp_pkg::heap_stat_t     stat
);

    localparam int KW    = ssp_pkg::KEY_W;
    localparam int IDX_W = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
    localparam int SZ_W  = $clog2(HEAP_DEPTH + 1);
    localparam int CH_W  = IDX_W + 1;

    typedef enum logic [2:0] {
        H_IDLE, H_UP, H_UP_FIN, H_POP_TOP, H_POP_LAST, H_DN_L, H_DN_R, H_DN_C
    } hstate_t;

    hstate_t           state_reg, state_next;
    logic [SZ_W-1:0]   size_reg, size_next;
    logic [IDX_W-1:0]  i_reg, i_next;
    logic [KW-1:0]     cur_reg, cur_next;
    logic [KW-1:0]     top_reg, top_next;
    logic [KW-1:0]     lval_reg, lval_next;

    logic [KW-1:0]     mem [HEAP_DEPTH];
    logic              we;
    logic [IDX_W-1:0]  wa, ra;
    logic [KW-1:0]     wd, rdata;

    logic [IDX_W-1:0]  new_idx, par_new, par_i;
    logic [CH_W-1:0]   l_idx, r_idx;
    logic              r_ok;
    logic [IDX_W-1:0]  m_idx;
    logic [KW-1:0]     m_val;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        rdata <= mem[ra];
    end

    assign new_idx = size_reg[IDX_W-1:0];
    assign par_new = IDX_W'((new_idx - 1'b1) >> 1);
    assign par_i   = IDX_W'((i_reg - 1'b1) >> 1);
    assign l_idx   = {i_reg, 1'b1};
    assign r_idx   = l_idx + 1'b1;
    assign r_ok    = 32'(r_idx) < 32'(size_reg);

    always_comb begin
        state_next = state_reg;
        size_next  = size_reg;
        i_next     = i_reg;
        cur_next   = cur_reg;
        top_next   = top_reg;
        lval_next  = lval_reg;
        we         = 1'b0;
        wa         = i_reg;
        wd         = cur_reg;
        ra         = '0;
        m_idx      = i_reg;
        m_val      = cur_reg;
        case (state_reg)
            H_IDLE: begin
                if (cmd.clear) begin
                    size_next = '0;
                end else if (cmd.push) begin
                    if (32'(size_reg) < HEAP_DEPTH) begin
                        size_next = size_reg + 1'b1;
                        if (size_reg == '0) begin
                            we = 1'b1;
                            wa = '0;
                            wd = cmd.key;
                        end else begin
                            i_next     = new_idx;
                            cur_next   = cmd.key;
                            ra         = par_new;
                            state_next = H_UP;
                        end
                    end
                end else if (cmd.pop) begin
                    ra         = '0;
                    state_next = H_POP_TOP;
                end
            end
            H_UP: begin
                we = 1'b1;
                if (rdata <= cur_reg) begin
                    wd         = cur_reg;
                    state_next = H_IDLE;
                end else begin
                    wd     = rdata;
                    i_next = par_i;
                    ra     = IDX_W'((par_i - 1'b1) >> 1);
                    if (par_i == '0) begin
                        state_next = H_UP_FIN;
                    end
                end
            end
            H_UP_FIN: begin
                we         = 1'b1;
                state_next = H_IDLE;
            end
            H_POP_TOP: begin
                top_next   = rdata;
                size_next  = size_reg - 1'b1;
                ra         = IDX_W'(size_reg - 1'b1);
                state_next = H_POP_LAST;
            end
            H_POP_LAST: begin
                cur_next   = rdata;
                i_next     = '0;
                state_next = (size_reg == '0) ? H_IDLE : H_DN_L;
            end
            H_DN_L: begin
                if (32'(l_idx) >= 32'(size_reg)) begin
                    we         = 1'b1;
                    state_next = H_IDLE;
                end else begin
                    ra         = l_idx[IDX_W-1:0];
                    state_next = H_DN_R;
                end
            end
            H_DN_R: begin
                lval_next  = rdata;
                ra         = r_idx[IDX_W-1:0];
                state_next = H_DN_C;
            end
            H_DN_C: begin
                if (lval_reg < cur_reg) begin
                    m_idx = l_idx[IDX_W-1:0];
                    m_val = lval_reg;
                end
                if (r_ok && (rdata < m_val)) begin
                    m_idx = r_idx[IDX_W-1:0];
                    m_val = rdata;
                end
                we = 1'b1;
                if (m_idx == i_reg) begin
                    wd         = cur_reg;
                    state_next = H_IDLE;
                end else begin
                    wd         = m_val;
                    i_next     = m_idx;
                    state_next = H_DN_L;
                end
            end
            default: begin
                state_next = H_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= H_IDLE;
            size_reg  <= '0;
        end else begin
            state_reg <= state_next;
            size_reg  <= size_next;
        end
        i_reg    <= i_next;
        cur_reg  <= cur_next;
        top_reg  <= top_next;
        lval_reg <= lval_next;
    end

    assign stat.busy    = (state_reg != H_IDLE);
    assign stat.empty   = (size_reg == '0);
    assign stat.top_key = top_reg;

endmodule

`default_nettype wire

[sv/ssp_checker.sv]
`default_nettype none

module ssp_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [5:0]  m_vertex,
    input wire logic [29:0] m_distance,
    input wire logic [1:0]  m_status,
    input wire logic        m_last
);

    // no new transaction taken while a result is on offer
    a_busy_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input ready while result pending");

    // an error result is always the only one of its transaction
    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status != ssp_pkg::STATUS_OK)) |-> m_last)
        else $error("error result without last");

    // rejected edges report vertex and distance as zero
    a_rej_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == ssp_pkg::STATUS_EDGE_REJECT)) |->
        ((m_vertex == 6'd0) && (m_distance == 30'd0)))
        else $error("rejected edge result not zero");

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_distance) && $stable(m_vertex)))
        else $error("result changed while stalled");

endmodule

bind single_source_shortest_path ssp_checker u_ssp_checker (.*);

`default_nettype wire
